// ===== rtl/core/cdq_pkg.sv =====
package cdq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // command from the controller to the datapath
  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/core/cdq_if.sv =====
interface cdq_in_if;
  logic                                valid;
  logic                                ready;
  cdq_pkg::op_e                        op;
  logic signed [cdq_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cdq_out_if #(
  parameter int unsigned CNT_W = 5
);
  logic                                valid;
  logic                                ready;
  logic signed [cdq_pkg::DATA_W-1:0]   pop_value;
  cdq_pkg::status_e                    status;
  logic [CNT_W-1:0]                    occupancy;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, output pop_value, output status, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  input is_empty, input is_full, output ready);
endinterface

// ===== rtl/core/cdq_ctrl.sv =====
module cdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdq_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.exec  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_RESP;
        end
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/cdq_datapath.sv =====
module cdq_datapath #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdq_pkg::cmd_t                     cmd_i,
  input  cdq_pkg::op_e                      op_i,
  input  logic signed [cdq_pkg::DATA_W-1:0] push_value_i,
  output logic signed [cdq_pkg::DATA_W-1:0] pop_value_o,
  output cdq_pkg::status_e                  status_o,
  output logic [CNT_W-1:0]                  occupancy_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  logic signed [cdq_pkg::DATA_W-1:0] mem [CAPACITY];

  logic [IDX_W-1:0]                  head_q, head_d;
  logic [IDX_W-1:0]                  tail_q, tail_d;
  logic [CNT_W-1:0]                  count_q, count_d;
  cdq_pkg::status_e                  status_q, status_d;
  logic                              pop_ok_q, pop_ok_d;
  logic signed [cdq_pkg::DATA_W-1:0] rd_data_q;

  logic             full, empty;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [IDX_W-1:0] head_fwd, head_back, tail_fwd, tail_back;

  assign full  = (count_q == FULL_CNT);
  assign empty = (count_q == '0);

  // wrap in both directions at the capacity
  assign head_fwd  = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
  assign head_back = (head_q == '0) ? LAST_IDX : head_q - IDX_W'(1);
  assign tail_fwd  = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
  assign tail_back = (tail_q == '0) ? LAST_IDX : tail_q - IDX_W'(1);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    status_d = status_q;
    pop_ok_d = pop_ok_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_q;
    rd_addr  = head_q;
    if (cmd_i.exec) begin
      status_d = cdq_pkg::ST_DONE;
      pop_ok_d = 1'b0;
      case (op_i)
        cdq_pkg::OP_PUSH_REAR: begin
          if (full) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = tail_q;
            tail_d  = tail_fwd;
            count_d = count_q + CNT_W'(1);
          end
        end
        cdq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_d = cdq_pkg::ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = head_back;
            head_d  = head_back;
            count_d = count_q + CNT_W'(1);
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = head_q;
            head_d   = head_fwd;
            count_d  = count_q - CNT_W'(1);
            pop_ok_d = 1'b1;
          end
        end
        cdq_pkg::OP_POP_REAR: begin
          if (empty) begin
            status_d = cdq_pkg::ST_EMPTY;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = tail_back;
            tail_d   = tail_back;
            count_d  = count_q - CNT_W'(1);
            pop_ok_d = 1'b1;
          end
        end
        default: begin
          status_d = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      status_q <= cdq_pkg::ST_DONE;
      pop_ok_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  assign pop_value_o = pop_ok_q ? rd_data_q : '0;
  assign status_o    = status_q;
  assign occupancy_o = count_q;
  assign is_empty_o  = empty;
  assign is_full_o   = full;

endmodule

// ===== rtl/core/circular_deque.sv =====
// a result is offered in the cycle after its item is accepted
// the controller holds off the next item until the result is taken, and a pop
//   reads the slot memory through its registered read port
// reset: rst_ni clears head, tail, count, status and the pop flag at once; slot contents stay undefined
module circular_deque #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  cdq_in_if.sink           in_i,
  cdq_out_if.source        out_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  cdq_pkg::cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  cdq_datapath #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (in_i.op),
    .push_value_i (in_i.push_value),
    .pop_value_o  (out_o.pop_value),
    .status_o     (out_o.status),
    .occupancy_o  (out_o.occupancy),
    .is_empty_o   (out_o.is_empty),
    .is_full_o    (out_o.is_full)
  );

endmodule

// ===== rtl/core/cdq_checker.sv =====
module cdq_checker #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [cdq_pkg::DATA_W-1:0] pop_value_i,
  input cdq_pkg::status_e                  status_i,
  input logic [CNT_W-1:0]                  occupancy_i,
  input logic                              is_empty_i,
  input logic                              is_full_i
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("no result after an accepted item");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((is_empty_i == (occupancy_i == '0)) &&
                     (is_full_i == (occupancy_i == FULL_CNT)) &&
                     (occupancy_i <= FULL_CNT)))
    else $error("occupancy and flags disagree");

  // a refused item leaves the queue at its limit and pops nothing
  a_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i != cdq_pkg::ST_DONE)) |->
      (pop_value_i == '0) &&
      ((status_i == cdq_pkg::ST_FULL && is_full_i) ||
       (status_i == cdq_pkg::ST_EMPTY && is_empty_i)))
    else $error("refusal status inconsistent with state");

endmodule

bind circular_deque cdq_checker #(
  .CAPACITY (CAPACITY)
) u_cdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pop_value_i (out_o.pop_value),
  .status_i    (out_o.status),
  .occupancy_i (out_o.occupancy),
  .is_empty_i  (out_o.is_empty),
  .is_full_i   (out_o.is_full)
);
